// ===== hw/rtl/dltm_pkg.sv =====
// Delta-list timer manager: shared types and constants.
// No dependencies.
package dltm_pkg;
  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_KILL    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic [1:0] FUNC_TICK    = 2'd3;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [1:0] MODE_INACTIVE  = 2'd0;
  localparam logic [1:0] MODE_ACTIVE    = 2'd1;
  localparam logic [1:0] MODE_TRIGGERED = 2'd2;

  localparam logic [31:0] DELTA_EXPIRED   = 32'd0;
  localparam logic [31:0] PERIOD_ONE_SHOT = 32'd0;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_RD_T, OP_UNLINK, OP_CLR_MODE, OP_SET_TRIG,
    OP_INS_EMPTY, OP_WALK_RD, OP_WALK_STEP, OP_INS_APPEND, OP_INS_BEFORE,
    OP_TICK_HEAD, OP_FIRE_RD, OP_LOAD_PERIOD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       id_ok;      // latched id in range
    logic [1:0] mode;       // mode of target timer
    logic       list_empty;
    logic       head_zero;  // head delta is zero (after read)
    logic       walk_go;    // delta[r] <= sv and r has successor
    logic       walk_le;    // delta[r] <= sv
    logic       period_zero;
  } dp_stat_t;
endpackage

// ===== hw/rtl/dltm_datapath.sv =====
// Delta-list timer manager datapath: list storage, walk pointer, arithmetic.
// Depends on dltm_pkg.
module dltm_datapath
  import dltm_pkg::*;
#(
  parameter int NUM_TIMERS = 16,
  parameter int IW = $clog2(NUM_TIMERS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dp_cmd_t         cmd,
  input  logic [3:0]      in_id,
  input  logic [31:0]     in_sv,
  input  logic [31:0]     in_cv,
  input  logic [31:0]     in_amt,
  output dp_stat_t        stat,
  output logic [3:0]      t_id
);
  localparam int AW = $clog2(NUM_TIMERS);
  localparam logic [IW-1:0] NONE = IW'(NUM_TIMERS);

  logic [IW-1:0] prev_r [NUM_TIMERS];
  logic [IW-1:0] next_r [NUM_TIMERS];
  logic [31:0]   delta_r [NUM_TIMERS];
  logic [31:0]   period_r [NUM_TIMERS];
  logic [1:0]    mode_r [NUM_TIMERS];
  logic [IW-1:0] head_r;

  logic [IW-1:0] t_r, r_r;
  logic [3:0]    id_r;
  logic [31:0]   sv_r, cv_r, amt_r;
  logic          id_ok_r;

  // latched copies of the entries under work
  logic [IW-1:0] tp_r, tn_r, rp_r, rn_r;
  logic [31:0]   td_r, rd_r, tper_r;
  logic [1:0]    tm_r;

  function automatic logic ix(input logic [IW-1:0] v);
    return v < NONE;
  endfunction

  assign t_id = id_r;
  assign stat.id_ok = id_ok_r;
  assign stat.mode = tm_r;
  assign stat.list_empty = !ix(head_r);
  assign stat.head_zero = (rd_r == DELTA_EXPIRED);
  assign stat.walk_le = (rd_r <= sv_r);
  assign stat.walk_go = (rd_r <= sv_r) && ix(rn_r);
  assign stat.period_zero = (tper_r == PERIOD_ONE_SHOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NONE;
      for (int i = 0; i < NUM_TIMERS; i++) mode_r[i] <= MODE_INACTIVE;
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          t_r <= IW'(in_id);
          id_r <= in_id;
          id_ok_r <= ({28'd0, in_id} < 32'(NUM_TIMERS));
          sv_r <= in_sv;
          cv_r <= in_cv;
          amt_r <= in_amt;
        end
        OP_RD_T: begin
          tm_r <= mode_r[t_r[AW-1:0]];
          tp_r <= prev_r[t_r[AW-1:0]];
          tn_r <= next_r[t_r[AW-1:0]];
          td_r <= delta_r[t_r[AW-1:0]];
          tper_r <= period_r[t_r[AW-1:0]];
        end
        OP_UNLINK: begin
          if (ix(tp_r)) next_r[tp_r[AW-1:0]] <= tn_r;
          else head_r <= tn_r;
          if (ix(tn_r)) begin
            prev_r[tn_r[AW-1:0]] <= tp_r;
            delta_r[tn_r[AW-1:0]] <= delta_r[tn_r[AW-1:0]] + td_r;
          end
          mode_r[t_r[AW-1:0]] <= MODE_INACTIVE;
          tm_r <= MODE_INACTIVE;
        end
        OP_CLR_MODE: begin
          mode_r[t_r[AW-1:0]] <= MODE_INACTIVE;
          tm_r <= MODE_INACTIVE;
        end
        OP_SET_TRIG: mode_r[t_r[AW-1:0]] <= MODE_TRIGGERED;
        OP_INS_EMPTY: begin
          prev_r[t_r[AW-1:0]] <= NONE;
          next_r[t_r[AW-1:0]] <= NONE;
          head_r <= t_r;
          delta_r[t_r[AW-1:0]] <= sv_r;
          period_r[t_r[AW-1:0]] <= cv_r;
          mode_r[t_r[AW-1:0]] <= MODE_ACTIVE;
        end
        OP_WALK_RD: begin
          r_r <= head_r;
          rd_r <= delta_r[head_r[AW-1:0]];
          rn_r <= next_r[head_r[AW-1:0]];
          rp_r <= prev_r[head_r[AW-1:0]];
        end
        OP_WALK_STEP: begin
          sv_r <= sv_r - rd_r;
          r_r <= rn_r;
          rd_r <= delta_r[rn_r[AW-1:0]];
          rn_r <= next_r[rn_r[AW-1:0]];
          rp_r <= prev_r[rn_r[AW-1:0]];
        end
        OP_INS_APPEND: begin
          prev_r[t_r[AW-1:0]] <= r_r;
          next_r[t_r[AW-1:0]] <= NONE;
          next_r[r_r[AW-1:0]] <= t_r;
          delta_r[t_r[AW-1:0]] <= sv_r - rd_r;
          period_r[t_r[AW-1:0]] <= cv_r;
          mode_r[t_r[AW-1:0]] <= MODE_ACTIVE;
        end
        OP_INS_BEFORE: begin
          prev_r[t_r[AW-1:0]] <= rp_r;
          next_r[t_r[AW-1:0]] <= r_r;
          if (ix(rp_r)) next_r[rp_r[AW-1:0]] <= t_r;
          else head_r <= t_r;
          prev_r[r_r[AW-1:0]] <= t_r;
          delta_r[r_r[AW-1:0]] <= rd_r - sv_r;
          delta_r[t_r[AW-1:0]] <= sv_r;
          period_r[t_r[AW-1:0]] <= cv_r;
          mode_r[t_r[AW-1:0]] <= MODE_ACTIVE;
        end
        OP_TICK_HEAD: begin
          if (delta_r[head_r[AW-1:0]] >= amt_r)
            delta_r[head_r[AW-1:0]] <= delta_r[head_r[AW-1:0]] - amt_r;
          else delta_r[head_r[AW-1:0]] <= DELTA_EXPIRED;
        end
        OP_FIRE_RD: begin
          // head becomes the target timer; rd_r holds its delta for the test
          t_r <= head_r;
          id_r <= 4'(head_r);
          rd_r <= delta_r[head_r[AW-1:0]];
          tp_r <= prev_r[head_r[AW-1:0]];
          tn_r <= next_r[head_r[AW-1:0]];
          td_r <= delta_r[head_r[AW-1:0]];
          tper_r <= period_r[head_r[AW-1:0]];
        end
        OP_LOAD_PERIOD: begin
          sv_r <= tper_r;
          cv_r <= tper_r;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/dltm_ctrl.sv =====
// Delta-list timer manager controller: sequences commands and emits results.
// Depends on dltm_pkg.
module dltm_ctrl
  import dltm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_rdy,
  output logic       out_valid,
  input  logic       out_rdy,
  output logic [1:0] o_kind,
  output logic       o_status,
  output logic       o_last,
  output logic       o_use_t,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DISPATCH, S_KILL, S_START, S_WALK, S_INSERT,
    S_TICK, S_FIRE_RD, S_FIRE, S_RELOAD, S_OUT
  } st_t;

  st_t st_r, st_nxt;
  logic [1:0] func_r, func_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic status_r, status_nxt, last_r, last_nxt, valid_r, valid_nxt;
  logic fire_r, fire_nxt;

  assign in_rdy = (st_r == S_IDLE);
  assign out_valid = valid_r;
  assign o_kind = kind_r;
  assign o_status = status_r;
  assign o_last = last_r;
  assign o_use_t = (kind_r != KIND_DONE);

  always_comb begin
    st_nxt = st_r; func_nxt = func_r; kind_nxt = kind_r; status_nxt = status_r;
    last_nxt = last_r; valid_nxt = valid_r; fire_nxt = fire_r;
    cmd.op = OP_NONE;
    case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LATCH; func_nxt = in_func; st_nxt = S_RD; fire_nxt = 1'b0;
      end
      S_RD: begin
        cmd.op = OP_RD_T; st_nxt = (func_r == FUNC_TICK) ? S_TICK : S_DISPATCH;
      end
      S_DISPATCH: begin
        kind_nxt = KIND_ACK; last_nxt = 1'b1; status_nxt = 1'b1;
        st_nxt = S_OUT;
        if (stat.id_ok) begin
          case (func_r)
            FUNC_START:
              if (stat.mode == MODE_INACTIVE || stat.mode == MODE_TRIGGERED) begin
                status_nxt = 1'b0; st_nxt = S_START;
              end
            FUNC_KILL: begin
              if (stat.mode == MODE_ACTIVE) cmd.op = OP_UNLINK;
              else if (stat.mode == MODE_TRIGGERED) cmd.op = OP_CLR_MODE;
              if (stat.mode == MODE_ACTIVE || stat.mode == MODE_TRIGGERED)
                status_nxt = 1'b0;
            end
            default: begin
              if (stat.mode == MODE_ACTIVE) cmd.op = OP_UNLINK;
              else if (stat.mode == MODE_TRIGGERED) cmd.op = OP_CLR_MODE;
              status_nxt = 1'b0; st_nxt = S_START;
            end
          endcase
        end
      end
      S_START: begin
        if (stat.list_empty) begin
          cmd.op = OP_INS_EMPTY; st_nxt = S_OUT;
        end else begin
          cmd.op = OP_WALK_RD; st_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_go) cmd.op = OP_WALK_STEP;
        else st_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.op = stat.walk_le ? OP_INS_APPEND : OP_INS_BEFORE; st_nxt = S_OUT;
      end
      S_TICK: begin
        if (stat.list_empty) begin
          kind_nxt = KIND_DONE; status_nxt = 1'b0; last_nxt = 1'b1; st_nxt = S_OUT;
        end else begin
          cmd.op = OP_TICK_HEAD; st_nxt = S_FIRE_RD;
        end
      end
      S_FIRE_RD: begin
        if (stat.list_empty) begin
          kind_nxt = KIND_DONE; status_nxt = 1'b0; last_nxt = 1'b1; st_nxt = S_OUT;
          fire_nxt = 1'b0;
        end else begin
          cmd.op = OP_FIRE_RD; st_nxt = S_FIRE;
        end
      end
      S_FIRE: begin
        if (!stat.head_zero) begin
          kind_nxt = KIND_DONE; status_nxt = 1'b0; last_nxt = 1'b1; st_nxt = S_OUT;
          fire_nxt = 1'b0;
        end else begin
          cmd.op = OP_UNLINK;
          kind_nxt = KIND_FIRED; status_nxt = 1'b0; last_nxt = 1'b0;
          fire_nxt = 1'b1; st_nxt = S_RELOAD;
        end
      end
      S_RELOAD: begin
        if (stat.period_zero) begin
          cmd.op = OP_SET_TRIG; st_nxt = S_OUT;
        end else begin
          cmd.op = OP_LOAD_PERIOD; st_nxt = S_START;
        end
      end
      S_OUT: begin
        if (!valid_r) valid_nxt = 1'b1;
        else if (out_rdy) begin
          valid_nxt = 1'b0;
          st_nxt = fire_r ? S_FIRE_RD : S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; valid_r <= 1'b0; fire_r <= 1'b0;
      func_r <= FUNC_START; kind_r <= KIND_ACK; status_r <= 1'b0; last_r <= 1'b0;
    end else begin
      st_r <= st_nxt; valid_r <= valid_nxt; fire_r <= fire_nxt;
      func_r <= func_nxt; kind_r <= kind_nxt; status_r <= status_nxt;
      last_r <= last_nxt;
    end
  end
endmodule

// ===== hw/rtl/delta_list_timer_manager_unit.sv =====
// Channel  Ports                     Payload
// in       in_tvalid/tready/tdata    func, timer_id, start_value, cycle_value, tick_amount
// out      out_tvalid/tready/tdata   result_kind, timer_id_out, status; last on tlast
// One item at a time; the next command is taken only after the last result.
// A start into a non-empty list steps past each entry whose delta is not above
// the value left; a tick lowers the head delta, then fires each expired head,
// marking one-shot timers triggered and reinserting periodic ones with the walk.
// A synchronous rst_n empties the list. A stalled result holds the block.
// Top level; depends on dltm_pkg, dltm_ctrl, dltm_datapath.
module delta_list_timer_manager_unit
  import dltm_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // func[1:0], timer_id[5:2], start_value[37:6],
                                  // cycle_value[69:38], tick_amount[101:70]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata, // result_kind[1:0], timer_id_out[5:2], status[6]
  output logic         out_tlast
);
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [1:0] kind;
  logic status, use_t;
  logic [3:0] t_id;

  dltm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_func(in_tdata[1:0]), .in_rdy(in_tready),
    .out_valid(out_tvalid), .out_rdy(out_tready), .o_kind(kind), .o_status(status),
    .o_last(out_tlast), .o_use_t(use_t), .cmd, .stat
  );

  dltm_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
    .clk, .rst_n, .cmd, .in_id(in_tdata[5:2]), .in_sv(in_tdata[37:6]),
    .in_cv(in_tdata[69:38]), .in_amt(in_tdata[101:70]), .stat, .t_id
  );

  assign out_tdata = {1'b0, status, (use_t ? t_id : 4'd0), kind};

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == KIND_DONE |-> out_tlast) else $error("done not last");
  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == KIND_FIRED |-> !out_tlast) else $error("fired last");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
endmodule

// ===== tb/sv/delta_list_timer_manager_unit_tb.sv =====
// Testbench for delta_list_timer_manager_unit: directed and random timer commands and ticks.
// Results are checked against an in-bench delta-list predictor; depends on dltm_pkg.
module delta_list_timer_manager_unit_tb;
  import dltm_pkg::*;

  localparam int NT = 16;
  localparam int NONE = NT;

  // first member in the top bits, so func lands in tdata[1:0]
  typedef struct packed {
    logic [31:0] amt;
    logic [31:0] cv;
    logic [31:0] sv;
    logic [3:0]  id;
    logic [1:0]  func;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] id;
    logic       st;
    logic       last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [103:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;

  delta_list_timer_manager_unit #(.NUM_TIMERS(NT)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // predictor state
  int unsigned lprev[NT];
  int unsigned lnext[NT];
  logic [31:0] dleft[NT];
  logic [31:0] period[NT];
  logic [1:0]  tmode[NT];
  int unsigned head = NONE;

  cmd_t pending[$];
  res_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;

  function automatic void unlink_entry(int unsigned t);
    int unsigned p;
    int unsigned n;
    p = lprev[t];
    n = lnext[t];
    if (p < NT) lnext[p] = n;
    else head = n;
    if (n < NT) begin
      lprev[n] = p;
      dleft[n] = dleft[n] + dleft[t];
    end
    tmode[t] = MODE_INACTIVE;
  endfunction

  function automatic bit kill_entry(int unsigned t);
    if (tmode[t] == MODE_TRIGGERED) begin
      tmode[t] = MODE_INACTIVE;
      return 0;
    end
    if (tmode[t] == MODE_ACTIVE) begin
      unlink_entry(t);
      return 0;
    end
    return 1;
  endfunction

  function automatic bit insert_entry(int unsigned t, logic [31:0] sv, logic [31:0] cv);
    int unsigned r;
    int unsigned p;
    int steps;
    steps = 0;
    if (tmode[t] != MODE_INACTIVE && tmode[t] != MODE_TRIGGERED) return 1;
    r = head;
    if (r >= NT) begin
      lprev[t] = NONE;
      lnext[t] = NONE;
      head = t;
    end else begin
      while (dleft[r] <= sv && lnext[r] < NT && steps < NT) begin
        sv = sv - dleft[r];
        r = lnext[r];
        steps++;
      end
      if (dleft[r] <= sv) begin
        lprev[t] = r;
        lnext[t] = NONE;
        lnext[r] = t;
        sv = sv - dleft[r];
      end else begin
        p = lprev[r];
        lprev[t] = p;
        lnext[t] = r;
        if (p < NT) lnext[p] = t;
        else head = t;
        lprev[r] = t;
        dleft[r] = dleft[r] - sv;
      end
    end
    dleft[t] = sv;
    period[t] = cv;
    tmode[t] = MODE_ACTIVE;
    return 0;
  endfunction

  function automatic void predict_timer_results(cmd_t c);
    int unsigned h;
    int nf;
    logic [31:0] per;
    bit st;
    bit dummy;
    nf = 0;
    st = 1;
    if (c.func == FUNC_TICK) begin
      h = head;
      if (h < NT) begin
        if (dleft[h] >= c.amt) dleft[h] = dleft[h] - c.amt;
        else dleft[h] = DELTA_EXPIRED;
        while (h < NT && dleft[h] == DELTA_EXPIRED && nf < NT) begin
          per = period[h];
          unlink_entry(h);
          if (per == PERIOD_ONE_SHOT) tmode[h] = MODE_TRIGGERED;
          else dummy = insert_entry(h, per, per);
          expected_results.push_back('{KIND_FIRED, h[3:0], 1'b0, 1'b0});
          nf++;
          h = head;
        end
      end
      expected_results.push_back('{KIND_DONE, 4'd0, 1'b0, 1'b1});
    end else begin
      if (c.func == FUNC_START) st = insert_entry(32'(c.id), c.sv, c.cv);
      else if (c.func == FUNC_KILL) st = kill_entry(32'(c.id));
      else begin
        dummy = kill_entry(32'(c.id));
        st = insert_entry(32'(c.id), c.sv, c.cv);
      end
      expected_results.push_back('{KIND_ACK, c.id, st, 1'b1});
    end
  endfunction

  function automatic cmd_t mk(logic [1:0] f, logic [3:0] id, logic [31:0] sv,
                              logic [31:0] cv, logic [31:0] amt);
    cmd_t c;
    c.func = f; c.id = id; c.sv = sv; c.cv = cv; c.amt = amt;
    return c;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_timer_results(cmd_t'(in_tdata[101:0]));
        in_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
        if (pending.size() > 0 && ($urandom_range(0, 1) == 0)) begin
          in_tdata <= {2'b00, pending.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end else if (!in_tvalid) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (pending.size() > 0) begin
          in_tdata <= {2'b00, pending.pop_front()};
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // monitor and checker
  int out_gap = 0;
  res_t got;
  res_t want;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[1:0], out_tdata[5:2], out_tdata[6], out_tlast};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d id=%0d st=%0d last=%0d",
                   $time, got.kind, got.id, got.st, got.last);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind)
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
          if (got.id !== want.id)
            $display("%0t: id expected %0d actual %0d", $time, want.id, got.id);
          if (got.st !== want.st)
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          if (got.last !== want.last)
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
          if (got !== want) errors++;
        end
        out_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
        out_tready <= (out_gap == 0);
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_tready <= (out_gap == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int k;
    for (int i = 0; i < NT; i++) tmode[i] = MODE_INACTIVE;
    // directed: empty tick, edges, refusals, zero start, wrap of all fields
    pending.push_back(mk(FUNC_TICK, 4'd0, 32'd0, 32'd0, 32'd0));
    pending.push_back(mk(FUNC_KILL, 4'd3, 32'd0, 32'd0, 32'd0));
    pending.push_back(mk(FUNC_START, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
    pending.push_back(mk(FUNC_START, 4'd0, 32'd5, 32'd5, 32'd0));
    pending.push_back(mk(FUNC_START, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
    pending.push_back(mk(FUNC_START, 4'd7, 32'd10, 32'd3, 32'd0));
    pending.push_back(mk(FUNC_START, 4'd8, 32'd10, 32'd0, 32'd0));
    pending.push_back(mk(FUNC_START, 4'd9, 32'd2, 32'd0, 32'd0));
    pending.push_back(mk(FUNC_TICK, 4'd0, 32'd0, 32'd0, 32'd0));
    pending.push_back(mk(FUNC_KILL, 4'd7, 32'd0, 32'd0, 32'd0));
    pending.push_back(mk(FUNC_RESTART, 4'd8, 32'd1, 32'd4, 32'd0));
    pending.push_back(mk(FUNC_RESTART, 4'd2, 32'd6, 32'd0, 32'd0));
    pending.push_back(mk(FUNC_TICK, 4'd0, 32'd0, 32'd0, 32'd100));
    pending.push_back(mk(FUNC_KILL, 4'd9, 32'd0, 32'd0, 32'd0));
    pending.push_back(mk(FUNC_TICK, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
    pending.push_back(mk(FUNC_TICK, 4'd0, 32'd0, 32'd0, 32'h5555_5555));
    pending.push_back(mk(FUNC_TICK, 4'd0, 32'd0, 32'd0, 32'hAAAA_AAAA));
    for (int i = 0; i < NT; i++) pending.push_back(mk(FUNC_RESTART, i[3:0], 32'd1, 32'd0, 32'd0));
    pending.push_back(mk(FUNC_TICK, 4'd0, 32'd0, 32'd0, 32'd1));
    // random: mostly small timeouts so ticks fire often
    for (k = 0; k < 226; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: pending.push_back(mk(FUNC_START, 4'($urandom), rand_val(),
                                      $urandom_range(0, 2) ? $urandom_range(0, 20) : rand_val(),
                                      $urandom));
        3:       pending.push_back(mk(FUNC_KILL, 4'($urandom), $urandom, $urandom, $urandom));
        4, 5:    pending.push_back(mk(FUNC_RESTART, 4'($urandom), rand_val(),
                                      $urandom_range(0, 20), $urandom));
        default: pending.push_back(mk(FUNC_TICK, 4'($urandom), $urandom, $urandom, rand_val()));
      endcase
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    stim_done = 1;
  end

  initial begin
    wait (stim_done || cycles >= 2000000);
    if (!stim_done) begin
      $display("TEST FAILED");
    end else begin
      if (errors == 0 && expected_results.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
    end
    $finish;
  end
endmodule
